// ----- hdl/prime_candidate_tester_macros.svh -----
//------------------------------------------------------------------------------
// prime_candidate_tester_macros
// Assertion macros shared by the prime candidate tester.
//------------------------------------------------------------------------------
`ifndef PRIME_CANDIDATE_TESTER_MACROS_SVH
`define PRIME_CANDIDATE_TESTER_MACROS_SVH

// Asserts that a condition implies a property on the same edge.
`define PCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pct assertion failed");

// Asserts that a condition implies a property on the next edge.
`define PCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pct assertion failed");

`endif

// ----- hdl/pct_pkg.sv -----
//------------------------------------------------------------------------------
// pct_pkg
// Shared types and constants of the prime candidate tester.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package pct_pkg;

   localparam int CandidateBits = 44;
   localparam int MaxRounds     = 5;
   localparam int WitnessFields = 5;
   localparam int ExpBits       = 17;
   localparam int ModBits       = 24;
   localparam int RoundBits     = 3;
   localparam int VerdictBits   = 3;

   localparam logic [VerdictBits-1:0] VERDICT_PRIME     = 3'd0;
   localparam logic [VerdictBits-1:0] VERDICT_EXPONENT  = 3'd1;
   localparam logic [VerdictBits-1:0] VERDICT_BACKDOOR  = 3'd2;
   localparam logic [VerdictBits-1:0] VERDICT_TRIVIAL   = 3'd3;
   localparam logic [VerdictBits-1:0] VERDICT_COMPOSITE = 3'd4;

   localparam logic [1:0] CSR_EXPONENT = 2'd0;
   localparam logic [1:0] CSR_MODULUS  = 2'd1;
   localparam logic [1:0] CSR_RESIDUE  = 2'd2;
   localparam logic [1:0] CSR_ROUNDS   = 2'd3;

   typedef struct packed {
      logic [CandidateBits-1:0] candidate;
      logic [CandidateBits-1:0] witness_0;
      logic [CandidateBits-1:0] witness_1;
      logic [CandidateBits-1:0] witness_2;
      logic [CandidateBits-1:0] witness_3;
      logic [CandidateBits-1:0] witness_4;
   } req_type;

   typedef struct packed {
      logic [VerdictBits-1:0]   verdict;
      logic [CandidateBits-1:0] tested_value;
   } rsp_type;

   // Handshake between the sequencer and one lane.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
      logic composite;
   } lane_ctl_type;

endpackage

// ----- hdl/pct_divider.sv -----
//------------------------------------------------------------------------------
// pct_divider
// Restoring divider taking one dividend bit per cycle; only the remainder is kept.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pct_divider #(
   parameter int W = pct_pkg::CandidateBits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] remainder
);

   localparam int CntBits = $clog2(W + 1);

   logic [W-1:0]       quo_ff, quo_in;
   logic [W:0]         rem_ff, rem_in;
   logic [W-1:0]       div_ff, div_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [W:0]         shifted;

   // One shift and conditional subtract per cycle while busy.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CntBits'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) rem_in = shifted - {1'b0, div_ff};
         else rem_in = shifted;
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   // A zero divisor leaves the dividend as the remainder.
   assign done      = done_ff;
   assign remainder = rem_ff[W-1:0];

endmodule

// ----- hdl/pct_lane.sv -----
//------------------------------------------------------------------------------
// pct_lane
// One Miller-Rabin round: base reduction, modular power and squarings.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pct_lane #(
   parameter int W = pct_pkg::CandidateBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [W-1:0]         n,
   input  logic [W-1:0]         d,
   input  logic [$clog2(W)-1:0] s,
   input  logic [W-1:0]         witness,
   output pct_pkg::lane_ctl_type ctl
);

   localparam int SBits   = $clog2(W);

   typedef enum logic [2:0] {
      ST_IDLE, ST_REDUCE, ST_POW, ST_MUL, ST_SQR, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [W-1:0]       r_ff, base_ff, e_ff, x_ff;
   logic [W-1:0]       ma_ff, mb_ff, acc_ff;
   logic               mul_sq_ff;   // which operand is updated by the multiply
   logic               in_pow_ff;
   logic [SBits-1:0]   j_ff;
   logic               comp_ff;
   logic               div_start;
   logic               div_done;
   logic [W-1:0]       div_rem;
   logic [W-1:0]       nm1, nm2;
   logic [W-1:0]       a_red;
   logic [W:0]         acc_sum, dbl_sum;
   logic [W-1:0]       acc_next, dbl_next;

   assign nm1 = n - W'(1);
   assign nm2 = n - W'(2);

   pct_divider #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (witness),
      .divisor  (nm2),
      .done     (div_done),
      .remainder(div_rem)
   );

   assign div_start = start;
   assign a_red     = (div_rem < W'(2)) ? div_rem + W'(2) : div_rem;

   // Shift-and-add modular multiply, one bit of the multiplier per cycle.
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, ma_ff};
   assign acc_next = (acc_sum >= {1'b0, n}) ? W'(acc_sum - {1'b0, n}) : acc_sum[W-1:0];
   assign dbl_sum  = {1'b0, ma_ff} + {1'b0, ma_ff};
   assign dbl_next = (dbl_sum >= {1'b0, n}) ? W'(dbl_sum - {1'b0, n}) : dbl_sum[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         comp_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               if (div_done) begin
                  // a is already below n since n-2 < n
                  base_ff  <= (a_red >= n) ? a_red - n : a_red;
                  r_ff     <= W'(1);
                  e_ff     <= d;
                  state_ff <= ST_POW;
               end
            end
            ST_POW: begin
               if (e_ff == '0) begin
                  x_ff <= r_ff;
                  if (r_ff == W'(1) || r_ff == nm1) begin
                     comp_ff  <= 1'b0;
                     state_ff <= ST_DONE;
                  end else begin
                     j_ff     <= SBits'(1);
                     state_ff <= ST_SQR;
                  end
               end else if (e_ff[0]) begin
                  ma_ff <= r_ff; mb_ff <= base_ff; acc_ff <= '0;
                  mul_sq_ff <= 1'b0; in_pow_ff <= 1'b1;
                  state_ff <= ST_MUL;
               end else begin
                  ma_ff <= base_ff; mb_ff <= base_ff; acc_ff <= '0;
                  mul_sq_ff <= 1'b1; in_pow_ff <= 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mb_ff == '0) begin
                  if (!in_pow_ff) begin
                     x_ff <= acc_ff;
                     if (acc_ff == nm1) begin
                        comp_ff  <= 1'b0;
                        state_ff <= ST_DONE;
                     end else if (acc_ff == W'(1)) begin
                        comp_ff  <= 1'b1;
                        state_ff <= ST_DONE;
                     end else begin
                        j_ff     <= j_ff + SBits'(1);
                        state_ff <= ST_SQR;
                     end
                  end else if (mul_sq_ff) begin
                     base_ff  <= acc_ff;
                     e_ff     <= e_ff >> 1;
                     state_ff <= ST_POW;
                  end else begin
                     r_ff <= acc_ff;
                     // squaring of the base follows for the same bit
                     ma_ff <= base_ff; mb_ff <= base_ff; acc_ff <= '0;
                     mul_sq_ff <= 1'b1;
                  end
               end else begin
                  if (mb_ff[0]) acc_ff <= acc_next;
                  ma_ff <= dbl_next;
                  mb_ff <= mb_ff >> 1;
               end
            end
            ST_SQR: begin
               if (j_ff >= s) begin
                  comp_ff  <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  ma_ff <= x_ff; mb_ff <= x_ff; acc_ff <= '0;
                  in_pow_ff <= 1'b0;
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign ctl.start     = start;
   assign ctl.busy      = (state_ff != ST_IDLE) && (state_ff != ST_DONE);
   assign ctl.done      = (state_ff == ST_DONE);
   assign ctl.composite = comp_ff;

endmodule

// ----- hdl/prime_candidate_tester.sv -----
// Flow: two residue divisions on the shared divider, then the rounds run side by side in
// lanes, their time set by the bit-serial modular multiplier (a squaring per exponent bit,
// and a multiply as well for each set bit).
// Throughput: one item at a time; the next is taken once the result is in its register.
// Reset: synchronous, active high; control and CSR registers return to reset values.
//------------------------------------------------------------------------------
// prime_candidate_tester
// Prime candidate filter with parallel Miller-Rabin lanes and a merge stage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prime_candidate_tester_macros.svh"

module prime_candidate_tester #(
   parameter int MAX_ROUNDS     = pct_pkg::MaxRounds
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pct_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pct_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_wdata
);

   localparam int W      = pct_pkg::CandidateBits;
   localparam int Lanes  = (MAX_ROUNDS < pct_pkg::WitnessFields) ? MAX_ROUNDS
                                                                 : pct_pkg::WitnessFields;
   localparam int SBits  = $clog2(W);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIVE, ST_DIVM, ST_CHECK, ST_RUN, ST_OUT
   } state_type;

   state_type                 state_ff;
   logic [pct_pkg::ExpBits-1:0]   exp_ff;
   logic [pct_pkg::ModBits-1:0]   mod_ff;
   logic [pct_pkg::ModBits-1:0]   res_ff;
   logic [pct_pkg::RoundBits-1:0] rnd_ff;
   logic [W-1:0]              n_ff, d_ff;
   logic [SBits-1:0]          s_ff;
   logic [W-1:0]              wit_ff [Lanes];
   logic [W-1:0]              erem_ff;
   logic [pct_pkg::VerdictBits-1:0] verdict_ff;
   logic                      rsp_valid_ff;
   pct_pkg::rsp_type          rsp_ff;
   logic                      div_start;
   logic [W-1:0]              div_dvd, div_dvs, div_rem;
   logic                      div_done;
   logic                      lane_start_ff;
   logic [Lanes-1:0]          lane_use;
   logic [Lanes-1:0]          lane_done_ff;
   logic [Lanes-1:0]          lane_comp_ff;
   pct_pkg::lane_ctl_type     lctl [Lanes];
   logic [W-1:0]              all_wit [pct_pkg::WitnessFields];
   logic [2:0]                rounds_sat;

   assign all_wit[0] = req_data.witness_0;
   assign all_wit[1] = req_data.witness_1;
   assign all_wit[2] = req_data.witness_2;
   assign all_wit[3] = req_data.witness_3;
   assign all_wit[4] = req_data.witness_4;

   assign rounds_sat = (rnd_ff > 3'(Lanes)) ? 3'(Lanes) : rnd_ff;
   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= 17'd17;
         mod_ff <= 24'd7899272;
         res_ff <= 24'd3;
         rnd_ff <= 3'd5;
      end else if (csr_valid) begin
         case (csr_index)
            pct_pkg::CSR_EXPONENT: exp_ff <= csr_wdata[pct_pkg::ExpBits-1:0];
            pct_pkg::CSR_MODULUS:  mod_ff <= csr_wdata[pct_pkg::ModBits-1:0];
            pct_pkg::CSR_RESIDUE:  res_ff <= csr_wdata[pct_pkg::ModBits-1:0];
            pct_pkg::CSR_ROUNDS:   rnd_ff <= csr_wdata[pct_pkg::RoundBits-1:0];
            default: ;
         endcase
      end
   end

   // Shared divider for the filter residues.
   assign div_start = (state_ff == ST_IDLE && req_valid) ||
                      (state_ff == ST_DIVE && div_done);
   assign div_dvd   = (state_ff == ST_IDLE) ? req_data.candidate : n_ff;
   assign div_dvs   = (state_ff == ST_IDLE) ? W'(exp_ff) : W'(mod_ff);

   pct_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_dvd), .divisor(div_dvs),
      .done(div_done), .remainder(div_rem)
   );

   // Round lanes.
   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      assign lane_use[g] = (3'(g) < rounds_sat);
      pct_lane #(.W(W)) u_lane (
         .clock(clock), .reset(reset),
         .start(lane_start_ff && lane_use[g]),
         .n(n_ff), .d(d_ff), .s(s_ff), .witness(wit_ff[g]),
         .ctl(lctl[g])
      );
   end

   // Sequencer and merge of lane results once all lanes are done.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         lane_start_ff <= 1'b0;
         lane_done_ff  <= '0;
         lane_comp_ff  <= '0;
      end else begin
         // The result register empties when taken, unless a new result loads it.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  n_ff <= req_data.candidate;
                  d_ff <= req_data.candidate - W'(1);
                  s_ff <= '0;
                  for (int i = 0; i < Lanes; i++) wit_ff[i] <= all_wit[i];
                  state_ff <= ST_DIVE;
               end
            end
            ST_DIVE: begin
               if (div_done) begin
                  erem_ff  <= div_rem;
                  state_ff <= ST_DIVM;
               end
            end
            ST_DIVM: begin
               // Strip factors of two from n-1, one per cycle, while dividing.
               if (d_ff != '0 && !d_ff[0]) begin
                  d_ff <= d_ff >> 1;
                  s_ff <= s_ff + SBits'(1);
               end
               if (div_done) begin
                  if (exp_ff != '0 && erem_ff == W'(1))
                     verdict_ff <= pct_pkg::VERDICT_EXPONENT;
                  else if (n_ff <= W'(mod_ff) || div_rem != W'(res_ff))
                     verdict_ff <= pct_pkg::VERDICT_BACKDOOR;
                  else if (n_ff <= W'(1) || (!n_ff[0] && n_ff != W'(2)))
                     verdict_ff <= pct_pkg::VERDICT_TRIVIAL;
                  else
                     verdict_ff <= pct_pkg::VERDICT_PRIME;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (d_ff != '0 && !d_ff[0]) begin
                  d_ff <= d_ff >> 1;
                  s_ff <= s_ff + SBits'(1);
               end else if (verdict_ff != pct_pkg::VERDICT_PRIME || n_ff == W'(2)
                            || rounds_sat == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  lane_start_ff <= 1'b1;
                  lane_done_ff  <= ~lane_use;
                  lane_comp_ff  <= '0;
                  state_ff      <= ST_RUN;
               end
            end
            ST_RUN: begin
               // The start pulse lasts the first cycle of the run.
               lane_start_ff <= 1'b0;
               for (int i = 0; i < Lanes; i++) begin
                  if (lctl[i].done) begin
                     lane_done_ff[i] <= 1'b1;
                     lane_comp_ff[i] <= lctl[i].composite;
                  end
               end
               if (&lane_done_ff && !lane_start_ff) begin
                  if (|lane_comp_ff) verdict_ff <= pct_pkg::VERDICT_COMPOSITE;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.verdict      <= verdict_ff;
                  rsp_ff.tested_value <= n_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PCT_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `PCT_ASSERT_NEXT(a_out_valid, clock, reset,
                    state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready), rsp_valid_ff)
   `PCT_ASSERT_IMP(a_run_start, clock, reset, lane_start_ff, state_ff == ST_RUN)

endmodule

// ----- tb/sv/tb.sv -----
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the prime candidate tester. An initial block queues
// directed and random candidates for several register settings. A clocked
// driver offers them and predicts each verdict on acceptance. A clocked
// monitor compares every result, field by field, with the oldest prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int QuietLimit = 200000;
   localparam int HoldCycles = 3000;

   typedef logic [pct_pkg::CandidateBits-1:0] value_type;
   typedef logic [pct_pkg::VerdictBits-1:0]   verdict_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   pct_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   pct_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_wdata;

   // Local copy of the register file.
   logic [pct_pkg::ExpBits-1:0] exp_filter;
   logic [pct_pkg::ModBits-1:0] bd_modulus;
   logic [pct_pkg::ModBits-1:0] bd_residue;
   logic [pct_pkg::RoundBits-1:0] mr_rounds;

   pct_pkg::req_type candidates_to_send[$];
   pct_pkg::rsp_type verdicts_due[$];
   int mismatches = 0;
   int sent_count = 0;
   int seen_count = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_done = 0;

   prime_candidate_tester u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Modular product of two values below m, with m above zero.
   function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return 64'(prod % 128'(m));
   endfunction

   function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] r;
      r = 64'd1;
      while (e != 0) begin
         if (e[0]) r = mod_mul(r, base, m);
         base = mod_mul(base, base, m);
         e = e >> 1;
      end
      return r;
   endfunction

   // Witness rounds on an odd candidate of at least three.
   function automatic verdict_type witness_rounds(pct_pkg::req_type r);
      logic [63:0] n, nm1, d, a, x;
      logic [63:0] w[5];
      int s, rounds;
      bit passed;
      n = 64'(r.candidate);
      nm1 = n - 64'd1;
      d = nm1;
      s = 0;
      w[0] = 64'(r.witness_0);
      w[1] = 64'(r.witness_1);
      w[2] = 64'(r.witness_2);
      w[3] = 64'(r.witness_3);
      w[4] = 64'(r.witness_4);
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      rounds = (mr_rounds > pct_pkg::MaxRounds) ? pct_pkg::MaxRounds : int'(mr_rounds);
      for (int i = 0; i < rounds; i++) begin
         a = w[i] % (n - 64'd2);
         if (a < 64'd2) a = a + 64'd2;
         x = mod_pow(a % n, d, n);
         if (x == 64'd1 || x == nm1) continue;
         passed = 0;
         for (int j = 1; j < s; j++) begin
            x = mod_mul(x, x, n);
            if (x == nm1) begin
               passed = 1;
               break;
            end
            if (x == 64'd1) return pct_pkg::VERDICT_COMPOSITE;
         end
         if (!passed) return pct_pkg::VERDICT_COMPOSITE;
      end
      return pct_pkg::VERDICT_PRIME;
   endfunction

   function automatic verdict_type predict_verdict(pct_pkg::req_type r);
      logic [63:0] n, rem;
      n = 64'(r.candidate);
      rem = (bd_modulus != 0) ? n % 64'(bd_modulus) : n;
      if (exp_filter != 0 && n % 64'(exp_filter) == 64'd1) return pct_pkg::VERDICT_EXPONENT;
      if (n <= 64'(bd_modulus) || rem != 64'(bd_residue)) return pct_pkg::VERDICT_BACKDOOR;
      if (n <= 64'd1 || (!n[0] && n != 64'd2)) return pct_pkg::VERDICT_TRIVIAL;
      if (n == 64'd2) return pct_pkg::VERDICT_PRIME;
      return witness_rounds(r);
   endfunction

   function automatic value_type rand_value(int bits);
      logic [63:0] v;
      v = {$urandom, $urandom};
      return value_type'(v & ((64'd1 << bits) - 64'd1));
   endfunction

   task automatic queue_candidate(value_type cand, value_type w);
      pct_pkg::req_type r;
      r.candidate = cand;
      r.witness_0 = w;
      r.witness_1 = ~w;
      r.witness_2 = w;
      r.witness_3 = ~w;
      r.witness_4 = w;
      candidates_to_send.push_back(r);
   endtask

   // Mostly candidates that satisfy the residue condition, the rest noise.
   task automatic queue_random(int count);
      pct_pkg::req_type r;
      logic [63:0] n;
      for (int i = 0; i < count; i++) begin
         n = 64'(rand_value($urandom_range(3, pct_pkg::CandidateBits)));
         if ($urandom_range(99) < 80) begin
            if (bd_modulus == 0) begin
               n = 64'(bd_residue);
            end else begin
               n = n - n % 64'(bd_modulus) + 64'(bd_residue);
               if (n <= 64'(bd_modulus)) n = n + 64'(bd_modulus);
               if (!n[0] && bd_modulus[0]) n = n + 64'(bd_modulus);
            end
         end
         r.candidate = value_type'(n);
         r.witness_0 = rand_value(pct_pkg::CandidateBits);
         r.witness_1 = rand_value(pct_pkg::CandidateBits);
         r.witness_2 = rand_value(pct_pkg::CandidateBits);
         r.witness_3 = rand_value(pct_pkg::CandidateBits);
         r.witness_4 = rand_value(pct_pkg::CandidateBits);
         candidates_to_send.push_back(r);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pct_pkg::CSR_EXPONENT: exp_filter = value[pct_pkg::ExpBits-1:0];
         pct_pkg::CSR_MODULUS:  bd_modulus = value[pct_pkg::ModBits-1:0];
         pct_pkg::CSR_RESIDUE:  bd_residue = value[pct_pkg::ModBits-1:0];
         pct_pkg::CSR_ROUNDS:   mr_rounds = value[pct_pkg::RoundBits-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] e, logic [31:0] m, logic [31:0] res,
                             logic [31:0] rounds);
      write_csr(pct_pkg::CSR_EXPONENT, e);
      write_csr(pct_pkg::CSR_MODULUS, m);
      write_csr(pct_pkg::CSR_RESIDUE, res);
      write_csr(pct_pkg::CSR_ROUNDS, rounds);
   endtask

   // Holds off until every queued item has been answered.
   task automatic wait_drained();
      do @(posedge clock);
      while (candidates_to_send.size() != 0 || req_valid || verdicts_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Stimulus, one register setting per phase.
   initial begin
      value_type all_ones;
      all_ones = '1;
      exp_filter = 17'd17;
      bd_modulus = 24'd7899272;
      bd_residue = 24'd3;
      mr_rounds = 3'd5;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings.
      queue_candidate('0, '0);
      queue_candidate(all_ones, all_ones);
      queue_candidate(44'd7899275, '0);
      queue_candidate(44'd23697819, all_ones);
      queue_random(20);
      wait_drained();

      // Odd candidates above two that are not 1 mod 3 get through to the rounds.
      set_config(3, 2, 1, 5);
      queue_candidate(44'd3, '0);
      queue_candidate(44'd5, all_ones);
      queue_candidate(44'd7, '0);
      queue_candidate(44'd9, '0);
      queue_candidate(44'd561, 44'd1);
      queue_candidate(44'd1105, all_ones);
      queue_candidate(44'd18, '0);
      queue_candidate(all_ones, 44'd12345);
      queue_random(170);
      wait_drained();

      // Filter of 65537, largest modulus, single round.
      set_config(65537, 16777215, 16777214, 1);
      queue_random(25);
      wait_drained();
      write_csr(pct_pkg::CSR_RESIDUE, 16777215);
      queue_candidate(44'd33554430, '0);
      queue_candidate(all_ones, '0);
      wait_drained();

      // Zero filter and zero modulus, no rounds.
      set_config(0, 0, 2, 0);
      queue_candidate(44'd2, '0);
      queue_candidate(44'd3, '0);
      wait_drained();
      write_csr(pct_pkg::CSR_RESIDUE, 1);
      queue_candidate(44'd1, all_ones);
      wait_drained();

      // Filter of one and a round count beyond the witness fields.
      set_config(1, 6, 5, 7);
      queue_random(35);
      wait_drained();

      // Upper write bits are dropped by the registers.
      set_config(32'hFFFF_FFFF, 32'hFF00_0003, 2, 2);
      queue_random(30);
      wait_drained();

      repeat (200) @(posedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("prime_candidate_tester test passed");
      end else begin
         $display("prime_candidate_tester test failed");
      end
      $finish;
   end

   // Sender: offers queued items and predicts each one that is taken.
   initial req_valid = 1'b0;
   initial req_data = '0;
   always @(posedge clock) begin
      pct_pkg::rsp_type due;
      bit idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            due.verdict = predict_verdict(req_data);
            due.tested_value = req_data.candidate;
            verdicts_due.push_back(due);
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            idle = !(sent_count >= 120 && sent_count < 180) && $urandom_range(99) < 18;
            if (candidates_to_send.size() != 0 && !idle) begin
               req_data <= candidates_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result, with one long hold-off.
   initial rsp_ready = 1'b0;
   always @(posedge clock) begin
      pct_pkg::rsp_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_count++;
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result for %0d", rsp_data.tested_value));
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_data.verdict !== due.verdict)
                  report_mismatch($sformatf("candidate %0d verdict %0d, want %0d",
                     due.tested_value, rsp_data.verdict, due.verdict));
               if (rsp_data.tested_value !== due.tested_value)
                  report_mismatch($sformatf("tested value %0d, want %0d",
                     rsp_data.tested_value, due.tested_value));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && seen_count == 60) begin
            hold_done = 1;
            hold_left = HoldCycles;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (seen_count >= 120 && seen_count < 180) ||
                         ($urandom_range(99) >= 18);
         end
      end
   end

   // Watchdog on cycles with no handshake, outside the long hold-off.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || hold_left > 0) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("prime_candidate_tester test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- prime_candidate_tester.f -----
+incdir+hdl
hdl/pct_pkg.sv
hdl/pct_divider.sv
hdl/pct_lane.sv
hdl/prime_candidate_tester.sv
tb/sv/tb.sv
